### hdl/tbed_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbed_pkg: shared types and constants for the two-button event detector
// Holds the configuration bundle, register map indexes and event code groups.
// ----------------------------------------------------------------------------
package tbed_pkg;

    localparam int BTN_W   = 2;
    localparam int CODE_W  = 4;
    localparam int DEB_W   = 8;
    localparam int HOLD_W  = 16;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [DEB_W-1:0]  DEBOUNCE_RESET  = 8'd5;
    localparam logic [HOLD_W-1:0] LONG_RESET      = 16'd200;
    localparam logic [HOLD_W-1:0] HOLD_MAX        = 16'hFFFF;
    localparam logic [BTN_W-1:0]  BTN_NONE        = 2'b00;

    // Register indexes, taken from paddr[2].
    localparam logic REG_DEBOUNCE = 1'b0;
    localparam logic REG_LONG     = 1'b1;

    // Event code groups: the button mask is added to the group base.
    localparam logic [CODE_W-1:0] EVT_NONE         = 4'd0;
    localparam logic [CODE_W-1:0] EVT_PRESS_BASE   = 4'd0;
    localparam logic [CODE_W-1:0] EVT_RELEASE_BASE = 4'd3;
    localparam logic [CODE_W-1:0] EVT_LONG_BASE    = 4'd6;

    typedef struct packed {
        logic [DEB_W-1:0]  debounce_ticks;
        logic [HOLD_W-1:0] long_press_ticks;
    } cfg_t;

endpackage

### hdl/tbed_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbed_cfg_regs: APB configuration registers
// Holds the debounce length and the long press length with read back.
// ----------------------------------------------------------------------------
module tbed_cfg_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tbed_pkg::APB_AW-1:0] paddr,
    input  logic [tbed_pkg::APB_DW-1:0] pwdata,
    output logic [tbed_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output tbed_pkg::cfg_t              cfg
);
    import tbed_pkg::*;

    logic [DEB_W-1:0]  debounce_reg;
    logic [HOLD_W-1:0] long_reg;
    logic              wr_en;

    assign wr_en = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RESET;
            long_reg     <= LONG_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                REG_DEBOUNCE: debounce_reg <= pwdata[DEB_W-1:0];
                REG_LONG:     long_reg     <= pwdata[HOLD_W-1:0];
                default:      debounce_reg <= debounce_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_DEBOUNCE: prdata = {{(APB_DW-DEB_W){1'b0}}, debounce_reg};
            REG_LONG:     prdata = {{(APB_DW-HOLD_W){1'b0}}, long_reg};
            default:      prdata = '0;
        endcase
    end

    assign cfg.debounce_ticks   = debounce_reg;
    assign cfg.long_press_ticks = long_reg;

endmodule

### hdl/tbed_pipe_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbed_pipe_reg: one valid/ready register stage
// Holds one transfer and takes a new one whenever it is empty or draining.
// ----------------------------------------------------------------------------
module tbed_pipe_reg #(
    parameter int WIDTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    logic             valid_reg;
    logic [WIDTH-1:0] data_reg;

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### hdl/tbed_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbed_core: debounce filter and press/release/long event logic
// Updates the button state once per tick as the tick moves to the result stage.
// ----------------------------------------------------------------------------
module tbed_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        tick_en,
    input  logic [tbed_pkg::BTN_W-1:0]  raw,
    input  tbed_pkg::cfg_t              cfg,
    output logic [tbed_pkg::CODE_W-1:0] event_code
);
    import tbed_pkg::*;

    logic [BTN_W-1:0]  filt_reg, filt_next;
    logic [BTN_W-1:0]  prev_reg, prev_next;
    logic [DEB_W-1:0]  dcnt_reg, dcnt_next;
    logic              seen_pressed_reg, seen_pressed_next;
    logic              seen_released_reg, seen_released_next;
    logic [HOLD_W-1:0] hold_reg, hold_next;
    logic              long_fired_reg, long_fired_next;
    logic [DEB_W:0]    dcnt_inc;
    logic [HOLD_W-1:0] hold_inc;

    always_comb begin
        filt_next          = filt_reg;
        prev_next          = prev_reg;
        dcnt_next          = '0;
        seen_pressed_next  = seen_pressed_reg;
        seen_released_next = seen_released_reg;
        hold_next          = hold_reg;
        long_fired_next    = long_fired_reg;
        event_code         = EVT_NONE;
        dcnt_inc           = {1'b0, dcnt_reg} + {{DEB_W{1'b0}}, 1'b1};
        hold_inc           = (hold_reg < HOLD_MAX) ? hold_reg + 16'd1 : hold_reg;

        if (raw != filt_reg) begin
            if (dcnt_inc >= {1'b0, cfg.debounce_ticks}) begin
                filt_next = raw;
            end else begin
                dcnt_next = dcnt_inc[DEB_W-1:0];
            end
        end

        if (filt_next != prev_reg) begin
            prev_next = filt_next;
            if (filt_next == BTN_NONE) begin
                // Release is reported only if no long event fired in this hold.
                if (seen_pressed_reg) begin
                    if (!long_fired_reg) begin
                        event_code = EVT_RELEASE_BASE + {2'b00, prev_reg};
                    end
                    long_fired_next = 1'b0;
                end
                seen_pressed_next = 1'b0;
            end else begin
                seen_pressed_next = 1'b1;
                if (seen_released_reg) begin
                    event_code = EVT_PRESS_BASE + {2'b00, filt_next};
                end
                seen_released_next = 1'b0;
            end
        end else if (filt_next != BTN_NONE) begin
            hold_next = hold_inc;
            if (hold_inc == cfg.long_press_ticks) begin
                long_fired_next = 1'b1;
                event_code      = EVT_LONG_BASE + {2'b00, filt_next};
            end
        end else begin
            hold_next          = '0;
            seen_released_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filt_reg          <= '0;
            prev_reg          <= '0;
            dcnt_reg          <= '0;
            seen_pressed_reg  <= 1'b0;
            seen_released_reg <= 1'b0;
            hold_reg          <= '0;
            long_fired_reg    <= 1'b0;
        end else if (tick_en) begin
            filt_reg          <= filt_next;
            prev_reg          <= prev_next;
            dcnt_reg          <= dcnt_next;
            seen_pressed_reg  <= seen_pressed_next;
            seen_released_reg <= seen_released_next;
            hold_reg          <= hold_next;
            long_fired_reg    <= long_fired_next;
        end
    end

endmodule

### hdl/two_button_event_detector_top.sv
// Each tick is held in the input register, and its event code in the result register.
// Throughput: one tick per cycle while m_ready holds high; the input and
// result registers form a two-stage pipeline with the event logic between.
// Reset: synchronous active-low aresetn clears both stages, all button state,
// and loads the debounce and long press registers with 5 and 200.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_button_event_detector_top: debounced two-button event detector
// Turns scan ticks of two buttons into press, release and long press events.
// ----------------------------------------------------------------------------
module two_button_event_detector_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_wheel_button_pressed,
    input  logic                        s_key_pressed,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [tbed_pkg::CODE_W-1:0] m_event_code,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tbed_pkg::APB_AW-1:0] paddr,
    input  logic [tbed_pkg::APB_DW-1:0] pwdata,
    output logic [tbed_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import tbed_pkg::*;

    cfg_t              cfg;
    logic              tick_valid;
    logic              res_ready;
    logic [BTN_W-1:0]  tick_raw;
    logic [CODE_W-1:0] code;

    tbed_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tbed_pipe_reg #(.WIDTH(BTN_W)) u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   ({s_key_pressed, s_wheel_button_pressed}),
        .out_valid (tick_valid),
        .out_ready (res_ready),
        .out_data  (tick_raw)
    );

    // The state advances exactly when a tick moves into the result register.
    tbed_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tick_en    (tick_valid && res_ready),
        .raw        (tick_raw),
        .cfg        (cfg),
        .event_code (code)
    );

    tbed_pipe_reg #(.WIDTH(CODE_W)) u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (tick_valid),
        .in_ready  (res_ready),
        .in_data   (code),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_event_code)
    );

endmodule

### hdl/tbed_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbed_checker: port-level assertions for the event detector
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module tbed_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [tbed_pkg::CODE_W-1:0] m_event_code,
    input logic                        pready
);
    import tbed_pkg::*;

    // A result waiting on a stalled consumer holds its code.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_code))
        else $error("result changed while stalled");

    // Only codes from none up to both-long are ever produced.
    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_event_code <= EVT_LONG_BASE + 4'd3)
        else $error("event code out of range");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // With the consumer ready, the pipeline never back-pressures the producer.
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && m_ready |-> s_ready)
        else $error("input stalled while output drains");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready dropped");

endmodule

bind two_button_event_detector_top tbed_checker u_tbed_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_event_code (m_event_code),
    .pready       (pready)
);

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression for the two-button event detector
// A table of directed ticks and register writes, then random phases of press
// and release runs under varied debounce and long press settings, with the
// sender and receiver idling at random. Every result transfer is compared
// against a cycle-free predictor of the detector kept inside the bench.
// ----------------------------------------------------------------------------
module tb;
    import tbed_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned BURST_CYCLES = 400;
    localparam int          NUM_ROWS     = 42;
    localparam int          NUM_PHASES   = 6;

    localparam logic [BTN_W-1:0] BTN_WHEEL = 2'b01;
    localparam logic [BTN_W-1:0] BTN_KEY   = 2'b10;
    localparam logic [BTN_W-1:0] BTN_BOTH  = 2'b11;

    localparam logic [CODE_W-1:0] EV_WHEEL_PRESS   = EVT_PRESS_BASE + CODE_W'(BTN_WHEEL);
    localparam logic [CODE_W-1:0] EV_KEY_PRESS     = EVT_PRESS_BASE + CODE_W'(BTN_KEY);
    localparam logic [CODE_W-1:0] EV_BOTH_PRESS    = EVT_PRESS_BASE + CODE_W'(BTN_BOTH);
    localparam logic [CODE_W-1:0] EV_WHEEL_RELEASE = EVT_RELEASE_BASE + CODE_W'(BTN_WHEEL);
    localparam logic [CODE_W-1:0] EV_KEY_RELEASE   = EVT_RELEASE_BASE + CODE_W'(BTN_KEY);
    localparam logic [CODE_W-1:0] EV_BOTH_RELEASE  = EVT_RELEASE_BASE + CODE_W'(BTN_BOTH);
    localparam logic [CODE_W-1:0] EV_WHEEL_LONG    = EVT_LONG_BASE + CODE_W'(BTN_WHEEL);
    localparam logic [CODE_W-1:0] EV_BOTH_LONG     = EVT_LONG_BASE + CODE_W'(BTN_BOTH);

    typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [BTN_W-1:0]  btn;
        logic [31:0]       reps;
        logic              cfg_reg;
        logic [31:0]       cfg_val;
        logic              chk;
        logic [CODE_W-1:0] code;
    } dir_row_t;

    typedef struct packed {
        logic [DEB_W-1:0]  deb;
        logic [HOLD_W-1:0] lng;
        logic [15:0]       items;
        logic [7:0]        src_pct;
        logic [7:0]        sink_pct;
    } phase_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic                s_wheel_button_pressed;
    logic                s_key_pressed;
    logic                m_valid;
    logic                m_ready;
    logic [CODE_W-1:0]   m_event_code;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // Predictor state and its copy of the registers.
    cfg_t              model_cfg    = '{debounce_ticks: DEBOUNCE_RESET,
                                        long_press_ticks: LONG_RESET};
    logic [BTN_W-1:0]  filt_btn     = BTN_NONE;
    logic [BTN_W-1:0]  prev_btn     = BTN_NONE;
    logic [DEB_W-1:0]  deb_cnt      = '0;
    logic              was_pressed  = 1'b0;
    logic              was_released = 1'b0;
    logic [HOLD_W-1:0] hold_cnt     = '0;
    logic              long_done    = 1'b0;

    logic [CODE_W-1:0] pending_codes [$];
    int unsigned       err_count    = 0;
    int unsigned       cycle_count  = 0;
    int unsigned       src_idle     = 0;
    int unsigned       sink_stall   = 0;
    logic              sink_hold    = 1'b0;
    event              burst_ev;

    dir_row_t          dir_rows [NUM_ROWS];
    phase_t            phases [NUM_PHASES];

    two_button_event_detector_top dut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_wheel_button_pressed (s_wheel_button_pressed),
        .s_key_pressed          (s_key_pressed),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_event_code           (m_event_code),
        .psel                   (psel),
        .penable                (penable),
        .pwrite                 (pwrite),
        .paddr                  (paddr),
        .pwdata                 (pwdata),
        .prdata                 (prdata),
        .pready                 (pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("two_button_event_detector_top regression: fail");
            $finish;
        end
    end

    function automatic logic [CODE_W-1:0] event_of(input logic [BTN_W-1:0] mask,
                                                   input logic [CODE_W-1:0] base);
        if (mask == BTN_NONE)
            return EVT_NONE;
        return base + CODE_W'(mask);
    endfunction

    // One scan tick through the detector: debounce, then classify the change.
    function automatic logic [CODE_W-1:0] detector_step(input logic [BTN_W-1:0] raw);
        logic [CODE_W-1:0] code;
        logic [DEB_W:0]    next_cnt;
        code = EVT_NONE;
        if (raw != filt_btn) begin
            next_cnt = {1'b0, deb_cnt} + 1'b1;
            if (next_cnt >= {1'b0, model_cfg.debounce_ticks}) begin
                filt_btn = raw;
                deb_cnt  = '0;
            end else begin
                deb_cnt = next_cnt[DEB_W-1:0];
            end
        end else begin
            deb_cnt = '0;
        end

        if (filt_btn != prev_btn) begin
            if (filt_btn == BTN_NONE) begin
                if (was_pressed) begin
                    if (!long_done)
                        code = event_of(prev_btn, EVT_RELEASE_BASE);
                    long_done = 1'b0;
                end
                was_pressed = 1'b0;
            end else begin
                was_pressed = 1'b1;
                if (was_released)
                    code = event_of(filt_btn, EVT_PRESS_BASE);
                was_released = 1'b0;
            end
            prev_btn = filt_btn;
        end else if (filt_btn != BTN_NONE) begin
            // The hold count survives a change between pressed values.
            if (hold_cnt != HOLD_MAX)
                hold_cnt = hold_cnt + 1'b1;
            if (hold_cnt == model_cfg.long_press_ticks) begin
                long_done = 1'b1;
                code      = event_of(filt_btn, EVT_LONG_BASE);
            end
        end else begin
            hold_cnt     = '0;
            was_released = 1'b1;
        end
        return code;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch: %s: got %0d, expected %0d", what, got, want);
        err_count++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_codes.size() == 0)
                report_mismatch("result transfer with nothing pending", m_event_code, 0);
            else if (m_event_code !== pending_codes[0])
                report_mismatch("event_code", m_event_code, pending_codes.pop_front());
            else
                void'(pending_codes.pop_front());
        end
    end

    always @(negedge aclk) begin
        if (sink_hold)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= sink_stall);
    end

    // Long receiver hold-off, counted here so the sender keeps offering ticks.
    always begin
        @(burst_ev);
        @(posedge aclk);
        sink_hold = 1'b1;
        repeat (BURST_CYCLES) @(posedge aclk);
        sink_hold = 1'b0;
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_tick(input logic [BTN_W-1:0] btn, input logic chk,
                             input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] pred;
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid                <= 1'b1;
        s_wheel_button_pressed <= btn[0];
        s_key_pressed          <= btn[1];
        do @(posedge aclk); while (!s_ready);
        pred = detector_step(btn);
        pending_codes.push_back(chk ? code : pred);
        @(negedge aclk);
    endtask

    task automatic wait_results();
        s_valid <= 1'b0;
        while (pending_codes.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic apb_write(input logic idx, input logic [APB_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read_check(input logic idx, input logic [APB_DW-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want)
            report_mismatch(idx == REG_DEBOUNCE ? "debounce_ticks readback"
                                                : "long_press_ticks readback",
                            prdata, want);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_reg(input logic idx, input logic [APB_DW-1:0] val);
        apb_write(idx, val);
        if (idx == REG_DEBOUNCE) begin
            model_cfg.debounce_ticks = val[DEB_W-1:0];
            apb_read_check(idx, APB_DW'(val[DEB_W-1:0]));
        end else begin
            model_cfg.long_press_ticks = val[HOLD_W-1:0];
            apb_read_check(idx, APB_DW'(val[HOLD_W-1:0]));
        end
    endtask

    function automatic dir_row_t row_tick(input logic [BTN_W-1:0] btn, input int unsigned reps,
                                          input logic chk, input logic [CODE_W-1:0] code);
        return '{kind: ROW_TICK, btn: btn, reps: reps, cfg_reg: REG_DEBOUNCE,
                 cfg_val: '0, chk: chk, code: code};
    endfunction

    function automatic dir_row_t row_cfg(input logic idx, input logic [APB_DW-1:0] val);
        return '{kind: ROW_CFG, btn: BTN_NONE, reps: 0, cfg_reg: idx,
                 cfg_val: val, chk: 1'b0, code: EVT_NONE};
    endfunction

    // Mostly debounced press and release runs, plus short glitches and noise.
    task automatic run_phase(input int unsigned budget);
        int unsigned      sent;
        int unsigned      len;
        int unsigned      span;
        int unsigned      pick;
        int unsigned      deb;
        logic [BTN_W-1:0] val;
        sent = 0;
        while (sent < budget) begin
            pick = $urandom_range(99);
            deb  = model_cfg.debounce_ticks;
            span = (model_cfg.long_press_ticks < 24) ? model_cfg.long_press_ticks + 3 : 24;
            if (pick < 70) begin
                if (filt_btn == BTN_NONE || $urandom_range(99) >= 65)
                    val = BTN_W'($urandom_range(1, 3));
                else
                    val = BTN_NONE;
                len = deb + $urandom_range(span);
                if (len == 0)
                    len = 1;
            end else if (pick < 85) begin
                val = BTN_W'($urandom_range(3));
                len = $urandom_range(1, (deb > 1) ? deb - 1 : 1);
            end else begin
                val = BTN_NONE;
                len = $urandom_range(1, 4);
            end
            for (int unsigned k = 0; k < len && sent < budget; k++) begin
                send_tick((pick >= 85) ? BTN_W'($urandom_range(3)) : val, 1'b0, EVT_NONE);
                sent++;
                if (sent == budget / 2)
                    wait_results();
            end
        end
    endtask

    initial begin
        aresetn                = 1'b0;
        s_valid                = 1'b0;
        s_wheel_button_pressed = 1'b0;
        s_key_pressed          = 1'b0;
        m_ready                = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;

        dir_rows = '{
            row_cfg(REG_DEBOUNCE, 32'd1),
            row_cfg(REG_LONG, 32'd10),
            // No stable released tick yet, so the first press is silent.
            row_tick(BTN_WHEEL, 1, 1'b1, EVT_NONE),
            row_tick(BTN_WHEEL, 3, 1'b0, EVT_NONE),
            row_tick(BTN_NONE, 1, 1'b1, EV_WHEEL_RELEASE),
            row_cfg(REG_DEBOUNCE, 32'd5),
            row_tick(BTN_NONE, 3, 1'b1, EVT_NONE),
            row_tick(BTN_WHEEL, 5, 1'b1, EV_WHEEL_PRESS),
            row_tick(BTN_WHEEL, 10, 1'b1, EV_WHEEL_LONG),
            row_tick(BTN_NONE, 5, 1'b1, EVT_NONE),
            row_tick(BTN_NONE, 2, 1'b0, EVT_NONE),
            row_tick(BTN_KEY, 5, 1'b1, EV_KEY_PRESS),
            row_tick(BTN_KEY, 1, 1'b0, EVT_NONE),
            row_tick(BTN_NONE, 5, 1'b1, EV_KEY_RELEASE),
            row_tick(BTN_BOTH, 5, 1'b1, EV_BOTH_PRESS),
            row_tick(BTN_BOTH, 10, 1'b1, EV_BOTH_LONG),
            row_tick(BTN_NONE, 5, 1'b1, EVT_NONE),
            row_tick(BTN_NONE, 2, 1'b0, EVT_NONE),
            row_tick(BTN_BOTH, 5, 1'b1, EV_BOTH_PRESS),
            row_tick(BTN_NONE, 5, 1'b1, EV_BOTH_RELEASE),
            row_tick(BTN_NONE, 2, 1'b0, EVT_NONE),
            row_tick(BTN_WHEEL, 5, 1'b1, EV_WHEEL_PRESS),
            // Moving from one pressed value to another gives no event.
            row_tick(BTN_BOTH, 5, 1'b1, EVT_NONE),
            row_tick(BTN_NONE, 5, 1'b0, EVT_NONE),
            row_tick(BTN_WHEEL, 4, 1'b0, EVT_NONE),
            row_tick(BTN_NONE, 3, 1'b1, EVT_NONE),
            row_cfg(REG_DEBOUNCE, 32'd0),
            row_tick(BTN_WHEEL, 1, 1'b1, EV_WHEEL_PRESS),
            row_tick(BTN_NONE, 1, 1'b1, EV_WHEEL_RELEASE),
            // Lowering the debounce below a running count accepts on the next tick.
            row_cfg(REG_DEBOUNCE, 32'd10),
            row_tick(BTN_KEY, 6, 1'b0, EVT_NONE),
            row_cfg(REG_DEBOUNCE, 32'd3),
            row_tick(BTN_KEY, 1, 1'b1, EV_KEY_PRESS),
            row_cfg(REG_LONG, 32'd0),
            row_tick(BTN_KEY, 100, 1'b0, EVT_NONE),
            row_tick(BTN_NONE, 3, 1'b1, EV_KEY_RELEASE),
            // A threshold at the top of the range stays silent over a short hold.
            row_cfg(REG_LONG, 32'd65535),
            row_tick(BTN_NONE, 2, 1'b0, EVT_NONE),
            row_tick(BTN_WHEEL, 3, 1'b1, EV_WHEEL_PRESS),
            row_tick(BTN_WHEEL, 20, 1'b1, EVT_NONE),
            row_tick(BTN_WHEEL, 5, 1'b0, EVT_NONE),
            row_tick(BTN_NONE, 3, 1'b1, EV_WHEEL_RELEASE)
        };

        phases = '{
            '{deb: 8'd1,   lng: 16'd1,     items: 16'd120, src_pct: 8'd0,  sink_pct: 8'd0},
            '{deb: 8'd3,   lng: 16'd12,    items: 16'd120, src_pct: 8'd64, sink_pct: 8'd0},
            '{deb: 8'd0,   lng: 16'd0,     items: 16'd120, src_pct: 8'd0,  sink_pct: 8'd64},
            '{deb: 8'd2,   lng: 16'd65535, items: 16'd100, src_pct: 8'd18, sink_pct: 8'd18},
            '{deb: 8'd255, lng: 16'd1,     items: 16'd420, src_pct: 8'd0,  sink_pct: 8'd0},
            '{deb: 8'd4,   lng: 16'd2,     items: 16'd130, src_pct: 8'd64, sink_pct: 8'd0}
        };

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        apb_read_check(REG_DEBOUNCE, APB_DW'(DEBOUNCE_RESET));
        apb_read_check(REG_LONG, APB_DW'(LONG_RESET));

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                wait_results();
                set_reg(dir_rows[i].cfg_reg, dir_rows[i].cfg_val);
            end else begin
                for (int unsigned n = 1; n <= dir_rows[i].reps; n++)
                    send_tick(dir_rows[i].btn, dir_rows[i].chk && n == dir_rows[i].reps,
                              dir_rows[i].code);
            end
        end

        foreach (phases[p]) begin
            wait_results();
            set_reg(REG_DEBOUNCE, APB_DW'(phases[p].deb));
            set_reg(REG_LONG, APB_DW'(phases[p].lng));
            src_idle   = phases[p].src_pct;
            sink_stall = phases[p].sink_pct;
            // The first phase opens with a long receiver hold-off to back up the pipe.
            if (p == 0)
                -> burst_ev;
            run_phase(phases[p].items);
        end

        wait_results();
        repeat (8) @(posedge aclk);
        if (err_count == 0)
            $display("two_button_event_detector_top regression: pass");
        else
            $display("two_button_event_detector_top regression: fail");
        $finish;
    end

endmodule
